>>> sv/windowed_class_score_vote_assert.svh
// Assertion macros used by the top RTL file of the windowed vote block.
`ifndef WINDOWED_CLASS_SCORE_VOTE_ASSERT_SVH
`define WINDOWED_CLASS_SCORE_VOTE_ASSERT_SVH
`ifndef SYNTHESIS
`define WCSV_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("windowed_class_score_vote: assertion failed");
`define WCSV_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("windowed_class_score_vote: assertion failed");
`else
`define WCSV_ASSERT(lbl, clk, rst, prop)
`define WCSV_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> sv/wcsv_pkg.sv
package wcsv_pkg;

   localparam int SCORE_W    = 16;
   localparam int SLOT_W     = 5;
   localparam int COUNT_W    = 7;
   localparam int WIN_CFG_W  = 7;
   localparam int NCLS_CFG_W = 6;
   localparam int PCT_W      = 7;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic CMD_SCORE = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   localparam logic [1:0] REG_WINDOW_SIZE = 2'd0;
   localparam logic [1:0] REG_NUM_CLASSES = 2'd1;
   localparam logic [1:0] REG_MIN_VOTE    = 2'd2;

   localparam logic [WIN_CFG_W-1:0]  RST_WINDOW_SIZE = 7'd50;
   localparam logic [NCLS_CFG_W-1:0] RST_NUM_CLASSES = 6'd32;
   localparam logic [PCT_W-1:0]      RST_MIN_VOTE    = 7'd20;

   typedef struct packed {
      logic [WIN_CFG_W-1:0]  window_size;
      logic [NCLS_CFG_W-1:0] num_classes;
      logic [PCT_W-1:0]      min_vote_percent;
   } csr_regs_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } scan_ctl_type;

endpackage

>>> sv/wcsv_req_if.sv
interface wcsv_req_if import wcsv_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      cmd;
   logic [SLOT_W-1:0]         class_slot;
   logic signed [SCORE_W-1:0] score;
   logic                      frame_end;

   modport source (output valid, cmd, class_slot, score, frame_end, input ready);
   modport sink (input valid, cmd, class_slot, score, frame_end, output ready);
endinterface

>>> sv/wcsv_rsp_if.sv
interface wcsv_rsp_if import wcsv_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [SLOT_W-1:0]  decided_class;
   logic               unknown;
   logic [COUNT_W-1:0] leader_votes;
   logic [COUNT_W-1:0] frames_held;

   modport source (output valid, decided_class, unknown, leader_votes, frames_held,
                   input ready);
   modport sink (input valid, decided_class, unknown, leader_votes, frames_held,
                 output ready);
endinterface

>>> sv/wcsv_ram.sv
module wcsv_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> sv/wcsv_csr.sv
module wcsv_csr import wcsv_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output csr_regs_type          regs
);
   csr_regs_type regs_ff, regs_in;

   always_comb begin
      regs_in = regs_ff;
      if (psel && penable && pwrite) begin
         unique case (paddr[3:2])
            REG_WINDOW_SIZE: regs_in.window_size = pwdata[WIN_CFG_W-1:0];
            REG_NUM_CLASSES: regs_in.num_classes = pwdata[NCLS_CFG_W-1:0];
            REG_MIN_VOTE:    regs_in.min_vote_percent = pwdata[PCT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_WINDOW_SIZE: prdata = CSR_DATA_W'(regs_ff.window_size);
         REG_NUM_CLASSES: prdata = CSR_DATA_W'(regs_ff.num_classes);
         REG_MIN_VOTE:    prdata = CSR_DATA_W'(regs_ff.min_vote_percent);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.window_size      <= RST_WINDOW_SIZE;
         regs_ff.num_classes      <= RST_NUM_CLASSES;
         regs_ff.min_vote_percent <= RST_MIN_VOTE;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign pready = 1'b1;
   assign regs   = regs_ff;
endmodule

>>> sv/wcsv_scan.sv
module wcsv_scan import wcsv_pkg::*; #(
   parameter int CW    = 5,
   parameter int SUM_W = 23,
   parameter int VW    = 7
) (
   input  logic                      clock,
   input  scan_ctl_type              ctl,
   input  logic [CW-1:0]             cls,
   input  logic signed [SCORE_W-1:0] score,
   input  logic                      hit,
   output logic [CW-1:0]             best_cls,
   output logic [VW-1:0]             leader
);
   logic signed [SUM_W-1:0] acc_ff, acc_in, best_sum_ff;
   logic [VW-1:0]           votes_ff, votes_in, leader_ff;
   logic [CW-1:0]           best_cls_ff;

   // Two adders sum a class's scores and hits over the window; at the class's last row
   // the same cycle compares both sums against the running best.
   always_comb begin
      acc_in   = (ctl.first ? '0 : acc_ff) + SUM_W'(score);
      votes_in = (ctl.first ? '0 : votes_ff) + VW'(hit);
   end

   always_ff @(posedge clock) begin
      if (ctl.valid) begin
         acc_ff   <= acc_in;
         votes_ff <= votes_in;
         if (ctl.last) begin
            if (cls == '0 || acc_in > best_sum_ff) begin
               best_sum_ff <= acc_in;
               best_cls_ff <= cls;
            end
            if (cls == '0 || votes_in > leader_ff) begin
               leader_ff <= votes_in;
            end
         end
      end
   end

   assign best_cls = best_cls_ff;
   assign leader   = leader_ff;
endmodule

>>> sv/windowed_class_score_vote.sv
// Channel   Dir  Handshake       Payload
// req_ch    in   valid / ready   cmd, class_slot, score, frame_end
// rsp_ch    out  valid / ready   decided_class, unknown, leader_votes, frames_held
// csr       in   APB write/read  window_size, num_classes, min_vote_percent
//
// A score or clear word that ends no frame leaves req_ch.ready high. A frame end
// word that leaves the window non-empty keeps req_ch.ready low through the SETUP,
// SCAN and FINISH states: the window is rescanned one score a cycle through the
// single read port of the score memory. FINISH waits while an earlier result
// still sits on rsp_ch. No clearing pass follows reset; the block goes straight
// to idle. The next word is taken once the result is in the output register,
// even while that result still waits on rsp_ch.ready.
`include "windowed_class_score_vote_assert.svh"

module windowed_class_score_vote import wcsv_pkg::*; #(
   parameter int MAX_WINDOW  = 64,
   parameter int MAX_CLASSES = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   wcsv_req_if.sink              req_ch,
   wcsv_rsp_if.source            rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);
   localparam int CW    = $clog2(MAX_CLASSES);
   localparam int NW    = $clog2(MAX_CLASSES + 1);
   localparam int RW    = $clog2(MAX_WINDOW);
   localparam int VW    = $clog2(MAX_WINDOW + 1);
   localparam int AW    = $clog2(MAX_WINDOW * MAX_CLASSES);
   localparam int SUM_W = SCORE_W + VW;
   localparam int MW    = CW + MAX_CLASSES;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SETUP  = 2'd1;
   localparam logic [1:0] ST_SCAN   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   csr_regs_type regs;

   logic [1:0]                state_ff, state_in;
   logic [RW-1:0]             write_slot_ff, write_slot_in;
   logic [VW-1:0]             fill_ff, fill_in;
   logic [MAX_CLASSES-1:0]    mask_ff, mask_in;
   logic                      open_ff, open_in;
   logic signed [SCORE_W-1:0] best_score_ff, best_score_in;
   logic [CW-1:0]             best_cls_ff, best_cls_in;
   logic [RW-1:0]             row_ff, row_in, start_row_ff, start_row_in;
   logic [VW-1:0]             k_ff, k_in;
   logic [CW-1:0]             cls_ff, cls_in, p1_cls_ff;
   logic                      issue_ff, issue_in;
   scan_ctl_type              p1_ff, p1_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]         out_cls_ff;
   logic                      out_unknown_ff;
   logic [COUNT_W-1:0]        out_votes_ff, out_fill_ff;
   logic                      load_out;

   logic [NW-1:0]             ncls;
   logic [VW-1:0]             win_eff;
   logic                      accept, slot_ok;
   logic [CW-1:0]             slot_cls;
   logic                      score_we, meta_we;
   logic [AW-1:0]             score_waddr, score_raddr;
   logic [MW-1:0]             meta_wdata, meta_rd;
   logic signed [SCORE_W-1:0] score_rd, scan_score;
   logic                      scan_hit;
   logic [CW-1:0]             scan_best_cls;
   logic [VW-1:0]             scan_leader;

   wcsv_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .regs    (regs)
   );

   always_comb begin
      if (regs.num_classes == '0) begin
         ncls = NW'(1);
      end else if (int'(regs.num_classes) > MAX_CLASSES) begin
         ncls = NW'(MAX_CLASSES);
      end else begin
         ncls = NW'(regs.num_classes);
      end
      if (int'(regs.window_size) > MAX_WINDOW) begin
         win_eff = VW'(MAX_WINDOW);
      end else begin
         win_eff = VW'(regs.window_size);
      end
   end

   assign accept   = req_ch.valid && req_ch.ready;
   assign slot_cls = CW'(req_ch.class_slot);
   assign slot_ok  = int'(req_ch.class_slot) < int'(ncls);
   assign score_we = accept && req_ch.cmd == CMD_SCORE && slot_ok;
   assign meta_we  = accept && req_ch.cmd == CMD_SCORE && req_ch.frame_end;
   assign score_waddr = AW'(int'(write_slot_ff) * MAX_CLASSES + int'(slot_cls));
   assign score_raddr = AW'(int'(row_ff) * MAX_CLASSES + int'(cls_ff));

   always_comb begin
      state_in      = state_ff;
      write_slot_in = write_slot_ff;
      fill_in       = fill_ff;
      mask_in       = mask_ff;
      open_in       = open_ff;
      best_score_in = best_score_ff;
      best_cls_in   = best_cls_ff;
      row_in        = row_ff;
      start_row_in  = start_row_ff;
      k_in          = k_ff;
      cls_in        = cls_ff;
      issue_in      = issue_ff;
      p1_in         = '0;
      meta_wdata    = '0;
      load_out      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_ch.cmd == CMD_CLEAR) begin
               write_slot_in = '0;
               fill_in       = '0;
               mask_in       = '0;
               open_in       = 1'b0;
               best_score_in = '0;
               best_cls_in   = '0;
            end else if (accept) begin
               if (slot_ok) begin
                  mask_in = mask_ff | (MAX_CLASSES'(1) << slot_cls);
                  if (!open_ff || req_ch.score > best_score_ff ||
                      (req_ch.score == best_score_ff && slot_cls < best_cls_ff)) begin
                     best_score_in = req_ch.score;
                     best_cls_in   = slot_cls;
                  end
                  open_in = 1'b1;
               end
               meta_wdata = {(open_in ? best_cls_in : CW'(0)), mask_in};
               if (req_ch.frame_end) begin
                  write_slot_in = (write_slot_ff == RW'(MAX_WINDOW - 1)) ? '0
                                  : write_slot_ff + RW'(1);
                  if (int'(fill_ff) + 1 > int'(win_eff)) begin
                     fill_in = win_eff;
                  end else begin
                     fill_in = fill_ff + VW'(1);
                  end
                  mask_in       = '0;
                  open_in       = 1'b0;
                  best_score_in = '0;
                  best_cls_in   = '0;
                  if (fill_in != '0) begin
                     state_in = ST_SETUP;
                  end
               end
            end
         end
         ST_SETUP: begin
            // Oldest frame in the window sits fill rows behind the write slot.
            if (int'(write_slot_ff) >= int'(fill_ff)) begin
               start_row_in = RW'(int'(write_slot_ff) - int'(fill_ff));
            end else begin
               start_row_in = RW'(int'(write_slot_ff) + MAX_WINDOW - int'(fill_ff));
            end
            row_in   = start_row_in;
            k_in     = '0;
            cls_in   = '0;
            issue_in = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (issue_ff) begin
               p1_in.valid = 1'b1;
               p1_in.first = (k_ff == '0);
               p1_in.last  = (k_ff == fill_ff - VW'(1));
               if (p1_in.last) begin
                  k_in   = '0;
                  row_in = start_row_ff;
                  if (int'(cls_ff) == int'(ncls) - 1) begin
                     issue_in = 1'b0;
                  end else begin
                     cls_in = cls_ff + CW'(1);
                  end
               end else begin
                  k_in   = k_ff + VW'(1);
                  row_in = (row_ff == RW'(MAX_WINDOW - 1)) ? '0 : row_ff + RW'(1);
               end
            end else if (!p1_ff.valid) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         write_slot_ff <= '0;
         fill_ff       <= '0;
         mask_ff       <= '0;
         open_ff       <= 1'b0;
         best_score_ff <= '0;
         best_cls_ff   <= '0;
         issue_ff      <= 1'b0;
         p1_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         write_slot_ff <= write_slot_in;
         fill_ff       <= fill_in;
         mask_ff       <= mask_in;
         open_ff       <= open_in;
         best_score_ff <= best_score_in;
         best_cls_ff   <= best_cls_in;
         issue_ff      <= issue_in;
         p1_ff         <= p1_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff       <= row_in;
      start_row_ff <= start_row_in;
      k_ff         <= k_in;
      cls_ff       <= cls_in;
      p1_cls_ff    <= cls_ff;
      if (load_out) begin
         out_cls_ff     <= SLOT_W'(scan_best_cls);
         out_unknown_ff <= int'(scan_leader) * 100 <
                           int'(regs.min_vote_percent) * int'(fill_ff);
         out_votes_ff   <= COUNT_W'(scan_leader);
         out_fill_ff    <= COUNT_W'(fill_ff);
      end
   end

   wcsv_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_WINDOW * MAX_CLASSES)) u_score_ram (
      .clock   (clock),
      .wr_en   (score_we),
      .wr_addr (score_waddr),
      .wr_data (req_ch.score),
      .rd_en   (issue_ff),
      .rd_addr (score_raddr),
      .rd_data (score_rd)
   );

   // Each row keeps its frame winner next to a mask of the classes that
   // arrived; a class missing from the mask counts as a zero score.
   wcsv_ram #(.WIDTH(MW), .DEPTH(MAX_WINDOW)) u_meta_ram (
      .clock   (clock),
      .wr_en   (meta_we),
      .wr_addr (write_slot_ff),
      .wr_data (meta_wdata),
      .rd_en   (issue_ff),
      .rd_addr (row_ff),
      .rd_data (meta_rd)
   );

   assign scan_score = meta_rd[p1_cls_ff] ? score_rd : '0;
   assign scan_hit   = (meta_rd[MW-1:MAX_CLASSES] == p1_cls_ff);

   wcsv_scan #(.CW(CW), .SUM_W(SUM_W), .VW(VW)) u_scan (
      .clock    (clock),
      .ctl      (p1_ff),
      .cls      (p1_cls_ff),
      .score    (scan_score),
      .hit      (scan_hit),
      .best_cls (scan_best_cls),
      .leader   (scan_leader)
   );

   assign req_ch.ready         = (state_ff == ST_IDLE);
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.decided_class = out_cls_ff;
   assign rsp_ch.unknown       = out_unknown_ff;
   assign rsp_ch.leader_votes  = out_votes_ff;
   assign rsp_ch.frames_held   = out_fill_ff;

   `WCSV_ASSERT(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
   `WCSV_ASSERT(a_fill_bound, clock, reset, int'(fill_ff) <= MAX_WINDOW)
   `WCSV_ASSERT(a_scan_exit, clock, reset, (state_ff == ST_SCAN && !issue_ff && !p1_ff.valid) |=> state_ff == ST_FINISH)
   `WCSV_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> state_ff == ST_IDLE && !rsp_valid_ff)
endmodule
